// ===== src/rbst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray / box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] inv_dir_x;
    logic signed [31:0] inv_dir_y;
    logic signed [31:0] inv_dir_z;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_enter;
    logic signed [31:0] t_exit;
  } out_res_t;

  // near and far slab distances of one axis
  typedef struct packed {
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } slab_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage
`default_nettype wire

// ===== src/ray_box_slab_test_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray against axis-aligned box slab test, signed fixed point, five stages.
// ----------------------------------------------------------------------------
// One ray is accepted every cycle while in_stall is low, and its result
// reaches the output register through the five-stage pipe (plane select,
// multiply, shift/saturate, x/y merge, z merge) whose slab multipliers are
// fully pipelined. A stalled output only holds the stages that are full:
// empty stages keep filling, so in_stall rises only once all five stages
// hold requests. The user must write box corners through the cfg port only
// while the block is idle; the block itself does not enforce this.
module ray_box_slab_test_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  rbst_pkg::in_req_t    in_req,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rbst_pkg::out_res_t   out_res,
  input  wire                  cfg_wr_en,
  input  wire  [2:0]           cfg_addr,
  input  wire  [31:0]          cfg_wdata
);
  import rbst_pkg::*;

  logic signed [31:0] box_min_x_r, box_min_y_r, box_min_z_r;
  logic signed [31:0] box_max_x_r, box_max_y_r, box_max_z_r;
  logic [5:1] v_r, v_nxt;
  logic [5:1] rdy;
  pipe_en_t   en;
  slab_t      slab_x, slab_y, slab_z;

  // a stage loads when it is empty or its successor advances
  always_comb begin
    rdy[5] = !v_r[5] || !out_stall;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[1] = rdy[1] ? in_valid : v_r[1];
    for (int k = 2; k <= 5; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
    en.s1 = rdy[1];
    en.s2 = rdy[2];
    en.s3 = rdy[3];
    en.s4 = rdy[4];
    en.s5 = rdy[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= 32'sd0;
      box_min_y_r <= 32'sd0;
      box_min_z_r <= 32'sd0;
      box_max_x_r <= 32'sd65536;
      box_max_y_r <= 32'sd65536;
      box_max_z_r <= 32'sd65536;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_BOX_MIN_X: box_min_x_r <= cfg_wdata;
        CFG_BOX_MIN_Y: box_min_y_r <= cfg_wdata;
        CFG_BOX_MIN_Z: box_min_z_r <= cfg_wdata;
        CFG_BOX_MAX_X: box_max_x_r <= cfg_wdata;
        CFG_BOX_MAX_Y: box_max_y_r <= cfg_wdata;
        CFG_BOX_MAX_Z: box_max_z_r <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  rbst_slab u_slab_x (
    .clk    (clk),
    .en     (en),
    .box_lo (box_min_x_r),
    .box_hi (box_max_x_r),
    .org    (in_req.origin_x),
    .inv    (in_req.inv_dir_x),
    .slab   (slab_x)
  );

  rbst_slab u_slab_y (
    .clk    (clk),
    .en     (en),
    .box_lo (box_min_y_r),
    .box_hi (box_max_y_r),
    .org    (in_req.origin_y),
    .inv    (in_req.inv_dir_y),
    .slab   (slab_y)
  );

  rbst_slab u_slab_z (
    .clk    (clk),
    .en     (en),
    .box_lo (box_min_z_r),
    .box_hi (box_max_z_r),
    .org    (in_req.origin_z),
    .inv    (in_req.inv_dir_z),
    .slab   (slab_z)
  );

  rbst_merge u_merge (
    .clk    (clk),
    .en     (en),
    .slab_x (slab_x),
    .slab_y (slab_y),
    .slab_z (slab_z),
    .res    (out_res)
  );

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[5];

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.hit) |-> (out_res.t_enter == 32'sd0 && out_res.t_exit == 32'sd0))
    else $error("rejected ray carries nonzero distances");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r == 5'b11111))
    else $error("input stalled with an empty stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1])
    else $error("accepted request lost at stage one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== src/rbst_slab.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_slab
// Slab distances of one axis in three stages: plane select and difference,
// multiply, floor shift with saturation.
// ----------------------------------------------------------------------------
module rbst_slab (
  input  wire                  clk,
  input  rbst_pkg::pipe_en_t   en,
  input  wire  signed [31:0]   box_lo,
  input  wire  signed [31:0]   box_hi,
  input  wire  signed [31:0]   org,
  input  wire  signed [31:0]   inv,
  output rbst_pkg::slab_t      slab
);
  import rbst_pkg::*;

  logic signed [32:0] d_near_r, d_far_r;
  logic signed [32:0] d_near_nxt, d_far_nxt;
  logic signed [31:0] inv_r;
  logic signed [64:0] p_near_r, p_far_r;
  logic signed [64:0] p_near_nxt, p_far_nxt;
  slab_t              slab_r, slab_nxt;
  logic signed [64:0] sh_near, sh_far;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic ok;
    ok = (&v[64:31]) || !(|v[64:31]);
    if (ok) begin
      sat32 = v[31:0];
    end else begin
      sat32 = v[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  // negative inverse direction swaps near and far planes
  always_comb begin
    if (inv[31]) begin
      d_near_nxt = 33'(box_hi) - 33'(org);
      d_far_nxt  = 33'(box_lo) - 33'(org);
    end else begin
      d_near_nxt = 33'(box_lo) - 33'(org);
      d_far_nxt  = 33'(box_hi) - 33'(org);
    end
  end

  assign p_near_nxt = 65'(d_near_r) * 65'(inv_r);
  assign p_far_nxt  = 65'(d_far_r) * 65'(inv_r);

  assign sh_near = p_near_r >>> FRAC_BITS;
  assign sh_far  = p_far_r >>> FRAC_BITS;

  always_comb begin
    slab_nxt.t_near = sat32(sh_near);
    slab_nxt.t_far  = sat32(sh_far);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_near_r <= d_near_nxt;
      d_far_r  <= d_far_nxt;
      inv_r    <= inv;
    end
    if (en.s2) begin
      p_near_r <= p_near_nxt;
      p_far_r  <= p_far_nxt;
    end
    if (en.s3) begin
      slab_r <= slab_nxt;
    end
  end

  assign slab = slab_r;

endmodule
`default_nettype wire

// ===== src/rbst_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_merge
// Interval narrowing in two stages: x with y, then the result with z.
// Rejection forces the distances to zero.
// ----------------------------------------------------------------------------
module rbst_merge (
  input  wire                  clk,
  input  rbst_pkg::pipe_en_t   en,
  input  rbst_pkg::slab_t      slab_x,
  input  rbst_pkg::slab_t      slab_y,
  input  rbst_pkg::slab_t      slab_z,
  output rbst_pkg::out_res_t   res
);
  import rbst_pkg::*;

  logic               hit_xy_r, hit_xy_nxt;
  logic signed [31:0] t0_r, t1_r, t0_nxt, t1_nxt;
  slab_t              z_r;
  out_res_t           res_r, res_nxt;

  always_comb begin
    hit_xy_nxt = !((slab_x.t_near > slab_y.t_far) || (slab_y.t_near > slab_x.t_far));
    t0_nxt = (slab_y.t_near > slab_x.t_near) ? slab_y.t_near : slab_x.t_near;
    t1_nxt = (slab_y.t_far < slab_x.t_far) ? slab_y.t_far : slab_x.t_far;
  end

  always_comb begin
    res_nxt = '0;
    if (hit_xy_r && !((t0_r > z_r.t_far) || (z_r.t_near > t1_r))) begin
      res_nxt.hit     = 1'b1;
      res_nxt.t_enter = (z_r.t_near > t0_r) ? z_r.t_near : t0_r;
      res_nxt.t_exit  = (z_r.t_far < t1_r) ? z_r.t_far : t1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      hit_xy_r <= hit_xy_nxt;
      t0_r     <= t0_nxt;
      t1_r     <= t1_nxt;
      z_r      <= slab_z;
    end
    if (en.s5) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== tb/ray_box_slab_test_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test_top_tb
// Self-checking bench for the ray / box slab test pipeline.
// A queue of rays feeds a clocked driver; a clocked monitor compares each
// result, field by field, with the outcome that an in-bench slab predictor
// worked out when the ray was accepted. The box is rewritten between phases
// once the pipe has drained: unit box, random boxes, full-range corners,
// inverted and flat boxes. Both sides idle at random, the receiver holds off
// once long enough to back the pipe up, and one phase runs with no idling.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top_tb;
  import rbst_pkg::*;

  localparam logic signed [31:0] ONE       = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic [2:0]         CFG_SPARE_6 = 3'd6;
  localparam logic [2:0]         CFG_SPARE_7 = 3'd7;
  localparam int                 NUM_PHASES  = 8;
  localparam int                 RAYS_PER_PHASE = 168;
  localparam int                 STALL_LIMIT = 2000;
  localparam int                 TAIL_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_res_t   out_res;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // box as the predictor sees it
  logic signed [31:0] box_lo [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic signed [31:0] box_hi [3] = '{ONE, ONE, ONE};

  in_req_t  ray_q [$];
  out_res_t slab_results_q [$];
  int       err_count = 0;
  int       idle_pct = 12;
  int       stall_burst = 0;
  int       quiet_cycles = 0;

  ray_box_slab_test_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [31:0] slab_dist(logic signed [31:0] plane,
                                                   logic signed [31:0] org,
                                                   logic signed [31:0] inv);
    longint diff;
    longint prod;
    longint q;
    diff = longint'(plane) - longint'(org);
    prod = diff * longint'(inv);
    q    = prod >>> FRAC_BITS;
    if (q > longint'(S32_MAX)) q = longint'(S32_MAX);
    if (q < longint'(S32_MIN)) q = longint'(S32_MIN);
    return q[31:0];
  endfunction

  function automatic out_res_t intersect_ray(in_req_t r);
    logic signed [31:0] org [3];
    logic signed [31:0] inv [3];
    logic signed [31:0] t_near [3];
    logic signed [31:0] t_far [3];
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    out_res_t res;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    inv = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
    for (int a = 0; a < 3; a++) begin
      // negative inverse direction swaps the planes; zero counts as positive
      t_near[a] = slab_dist(inv[a] < 0 ? box_hi[a] : box_lo[a], org[a], inv[a]);
      t_far[a]  = slab_dist(inv[a] < 0 ? box_lo[a] : box_hi[a], org[a], inv[a]);
    end
    res = '0;
    t0 = t_near[0];
    t1 = t_far[0];
    for (int a = 1; a < 3; a++) begin
      if (t0 > t_far[a] || t_near[a] > t1) return res;
      if (t_near[a] > t0) t0 = t_near[a];
      if (t_far[a] < t1) t1 = t_far[a];
    end
    res.hit     = 1'b1;
    res.t_enter = t0;
    res.t_exit  = t1;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] pick_small(int unsigned units);
    return int'($urandom_range(2 * units * 65536)) - int'(units * 65536);
  endfunction

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(6))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  function automatic longint pick_between(logic signed [31:0] a, logic signed [31:0] b);
    longint lo;
    longint span;
    longint unsigned off;
    lo   = (a < b) ? longint'(a) : longint'(b);
    span = ((a < b) ? longint'(b) : longint'(a)) - lo;
    off  = (longint'($urandom) * longint'(span + 1)) >> 32;
    return lo + longint'(off);
  endfunction

  // ray that passes through a random point of the box at a random distance
  function automatic in_req_t aimed_ray();
    longint target;
    longint inv;
    longint reach;
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    in_req_t r;
    for (int a = 0; a < 3; a++) begin
      target = pick_between(box_lo[a], box_hi[a]);
      inv    = longint'(pick_small(4));
      if ($urandom_range(9) == 0) inv = 0;
      reach  = longint'($urandom_range(4 * 65536));
      if (inv == 0) begin
        org[a] = target[31:0];
      end else begin
        org[a] = 32'(target - (reach * 65536) / inv);
      end
      dir[a] = inv[31:0];
    end
    r.origin_x  = org[0];
    r.origin_y  = org[1];
    r.origin_z  = org[2];
    r.inv_dir_x = dir[0];
    r.inv_dir_y = dir[1];
    r.inv_dir_z = dir[2];
    return r;
  endfunction

  function automatic in_req_t random_ray();
    int unsigned k;
    in_req_t r;
    k = $urandom_range(99);
    if (k < 50) begin
      r = aimed_ray();
    end else if (k < 70) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (k < 80) begin
      r = {pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge()};
    end else begin
      r = {pick_small(8), pick_small(8), pick_small(8),
           pick_small(4), pick_small(4), pick_small(4)};
    end
    return r;
  endfunction

  task automatic push_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                          logic signed [31:0] oz, logic signed [31:0] ix,
                          logic signed [31:0] iy, logic signed [31:0] iz);
    ray_q.push_back({ox, oy, oz, ix, iy, iz});
  endtask

  task automatic write_box(logic [2:0] idx, logic signed [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BOX_MIN_X: box_lo[0] = val;
      CFG_BOX_MIN_Y: box_lo[1] = val;
      CFG_BOX_MIN_Z: box_lo[2] = val;
      CFG_BOX_MAX_X: box_hi[0] = val;
      CFG_BOX_MAX_Y: box_hi[1] = val;
      CFG_BOX_MAX_Z: box_hi[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_box(logic signed [31:0] lo [3], logic signed [31:0] hi [3]);
    write_box(CFG_BOX_MIN_X, lo[0]);
    write_box(CFG_BOX_MIN_Y, lo[1]);
    write_box(CFG_BOX_MIN_Z, lo[2]);
    write_box(CFG_BOX_MAX_X, hi[0]);
    write_box(CFG_BOX_MAX_Y, hi[1]);
    write_box(CFG_BOX_MAX_Z, hi[2]);
    // spare indexes must leave the box alone
    write_box(CFG_SPARE_6, $urandom);
    write_box(CFG_SPARE_7, $urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (ray_q.size() != 0 || in_valid || slab_results_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic flag_mismatch(string msg);
    if (err_count < 100) $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    logic    nxt_valid;
    in_req_t nxt_req;
    nxt_valid = in_valid;
    nxt_req   = in_req;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        slab_results_q.push_back(intersect_ray(in_req));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && ray_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_valid = 1'b1;
        nxt_req   = ray_q.pop_front();
      end
    end
    in_valid <= nxt_valid;
    in_req   <= nxt_req;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch
    out_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (slab_results_q.size() == 0) begin
          flag_mismatch($sformatf("result with no ray pending (hit=%0b enter=%h exit=%h)",
                                  out_res.hit, out_res.t_enter, out_res.t_exit));
        end else begin
          want = slab_results_q.pop_front();
          if (out_res.hit !== want.hit)
            flag_mismatch($sformatf("hit got %b want %b", out_res.hit, want.hit));
          if (out_res.t_enter !== want.t_enter)
            flag_mismatch($sformatf("t_enter got %h want %h", out_res.t_enter, want.t_enter));
          if (out_res.t_exit !== want.t_exit)
            flag_mismatch($sformatf("t_exit got %h want %h", out_res.t_exit, want.t_exit));
        end
      end
      if (stall_burst > 0) begin
        out_stall <= 1'b1;
        stall_burst--;
      end else begin
        out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rays against the reset unit box
    push_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);              // diagonal hit
    push_ray(2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE);  // far plane first
    push_ray(ONE / 2, ONE / 2, ONE / 2, ONE, 0, 0);         // zero inverse inside
    push_ray(-ONE, ONE / 2, ONE / 2, ONE, 0, 0);            // zero inverse, rejects
    push_ray(-ONE, -3 * ONE, ONE / 2, ONE, ONE, ONE);       // reject on y
    push_ray(-ONE, -ONE, -3 * ONE, ONE, ONE, ONE);          // reject on z
    push_ray(-ONE, -2 * ONE, -ONE - ONE / 2, ONE, ONE, ONE); // touch on y
    push_ray(-ONE, -ONE, -2 * ONE, ONE, ONE, ONE);          // touch on z
    push_ray(0, 0, 0, 0, 0, 0);
    push_ray(-1, -1, -1, -1, -1, -1);
    push_ray(1, 1, 1, 3, 3, 3);                             // floor of negative
    push_ray(-1, 2, -3, -5, 7, -11);
    push_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
    push_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
    push_ray(S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN);
    push_ray(S32_MAX, S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX);
    push_ray(0, 0, 0, S32_MIN, S32_MIN, S32_MIN);
    push_ray(0, 0, 0, S32_MAX, S32_MAX, S32_MAX);
    push_ray(S32_MIN, 0, S32_MAX, 1, -1, 1);
    push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_ray(~$urandom, ~$urandom, ~$urandom, ~$urandom, ~$urandom, ~$urandom);

    for (int p = 1; p < NUM_PHASES; p++) begin
      wait_drained();
      for (int a = 0; a < 3; a++) begin
        case (p)
          1: begin lo[a] = 0; hi[a] = ONE; end
          3: begin lo[a] = S32_MIN; hi[a] = S32_MAX; end
          4: begin
            lo[a] = pick_small(8);
            hi[a] = lo[a] - int'($urandom_range(4 * 65536, 1));
          end
          5: begin lo[a] = pick_small(8); hi[a] = lo[a]; end
          6: begin lo[a] = $urandom; hi[a] = $urandom; end
          default: begin
            lo[a] = pick_small(16);
            hi[a] = lo[a] + int'($urandom_range(8 * 65536));
          end
        endcase
      end
      load_box(lo, hi);
      idle_pct = (p == 3) ? 0 : 12;
      for (int i = 0; i < RAYS_PER_PHASE; i++) ray_q.push_back(random_ray());
      if (p == 2) begin
        // hold the receiver off long enough to back the whole pipe up
        repeat (20) @(negedge clk);
        stall_burst = 80;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (slab_results_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", slab_results_q.size()));
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
